// ----- hw/rtl/crh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code history ring package
// Types and constants used by the code history ring.
// ----------------------------------------------------------------------------
package crh_pkg;

  // Default number of entries held in the ring.
  localparam int DEPTH_DEF = 32;

  // Widths of the item fields.
  localparam int VALUE_W = 32;
  localparam int CWIDTH_W = 8;
  localparam int SEQ_W = 32;
  localparam int FILL_W = 6;

  // Operation codes carried in the kind field.
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_GET   = 2'd1,
    KIND_POP   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // Input item.
  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  push_value;
    logic [CWIDTH_W-1:0] push_width;
    logic [SEQ_W-1:0]    seq_number;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic                ok;
    logic [VALUE_W-1:0]  code_value;
    logic [CWIDTH_W-1:0] code_width;
    logic [SEQ_W-1:0]    oldest_number;
    logic [SEQ_W-1:0]    newest_number;
    logic [FILL_W-1:0]   fill_count;
  } out_item_t;

endpackage

// ----- hw/rtl/code_history_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code history ring
// Overwriting ring of code values and byte widths, addressed by an absolute
// sequence number, with a pending-read cursor for pops.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                          | Moves
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data    | one operation per transfer
//   result  | out_valid, out_ready, out_data | one result per operation
//
// Each operation passes from transfer to result through the input register,
// where the window arithmetic runs and the entry RAM is written or read, and
// then the result register, fed by the RAM's registered read.
// One operation is taken every cycle while results are being taken.
// Reset clears the pointers, counters and valid flags at once; no clearing
// pass is needed since only pushed entries are ever read.
// A stalled result holds the input stage, which then holds in_ready low.
//
module code_history_ring
  import crh_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = VALUE_W + CWIDTH_W;

  // Slot arithmetic modulo DEPTH; the sum always stays below twice DEPTH.
  function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
    logic [SW-1:0] red;
    begin
      red = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
      wrap_slot = red[AW-1:0];
    end
  endfunction

  // Pipeline registers.
  logic      in_v_r;
  in_item_t  in_r;
  logic      out_v_r;
  logic      ok_r;
  logic      rd_r;
  logic [SEQ_W-1:0]  oldest_r;
  logic [SEQ_W-1:0]  newest_r;
  logic [FILL_W-1:0] fill_r;

  // Ring state.
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    held_r, held_nxt;
  logic [SEQ_W-1:0] total_r, total_nxt;
  logic [SEQ_W-1:0] cursor_r, cursor_nxt;

  logic adv;
  logic ok_nxt;
  logic rd_nxt;
  logic wr_en;
  logic rd_en;
  logic [AW-1:0] slot;
  logic [EW-1:0] rd_entry;

  logic [SEQ_W-1:0] held32;
  logic [SEQ_W-1:0] oldest;
  logic [SEQ_W-1:0] cursor_lag;
  logic [SEQ_W-1:0] get_rel;
  logic [SEQ_W-1:0] held32_nxt;
  logic             not_full;
  logic             pulled;
  logic [CW-1:0]    pop_rel;

  // Handshake: the input stage moves on when the result stage is free.
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  // Window arithmetic on the current state.
  assign held32     = SEQ_W'(held_r);
  assign oldest     = total_r - held32;
  assign cursor_lag = total_r - cursor_r;
  assign get_rel    = in_r.seq_number - oldest;
  assign not_full   = (held_r < CW'(DEPTH));
  assign pulled     = (cursor_lag > held32);
  assign pop_rel    = pulled ? '0 : held_r - cursor_lag[CW-1:0];

  // Next state and result flags for the operation in the input register.
  always_comb begin
    head_nxt   = head_r;
    held_nxt   = held_r;
    total_nxt  = total_r;
    cursor_nxt = cursor_r;
    ok_nxt     = 1'b1;
    rd_nxt     = 1'b0;
    wr_en      = 1'b0;
    slot       = head_r;
    case (in_r.kind)
      KIND_PUSH: begin
        wr_en     = 1'b1;
        total_nxt = total_r + SEQ_W'(1);
        if (not_full) begin
          slot     = wrap_slot(SW'(head_r) + SW'(held_r));
          held_nxt = held_r + CW'(1);
        end else begin
          slot     = head_r;
          head_nxt = wrap_slot(SW'(head_r) + SW'(1));
        end
        // The cursor never falls behind the oldest held entry.
        if ((cursor_lag + SEQ_W'(1)) > SEQ_W'(held_nxt)) begin
          cursor_nxt = total_nxt - SEQ_W'(held_nxt);
        end
      end
      KIND_GET: begin
        ok_nxt = (held_r != '0) && (get_rel < held32);
        rd_nxt = ok_nxt;
        slot   = wrap_slot(SW'(head_r) + SW'(get_rel[CW-1:0]));
      end
      KIND_POP: begin
        ok_nxt = (held_r != '0) && (cursor_lag != '0);
        rd_nxt = ok_nxt;
        slot   = wrap_slot(SW'(head_r) + SW'(pop_rel));
        if (held_r != '0) begin
          if (pulled) begin
            cursor_nxt = oldest + SEQ_W'(ok_nxt);
          end else begin
            cursor_nxt = cursor_r + SEQ_W'(ok_nxt);
          end
        end
      end
      KIND_CLEAR: begin
        cursor_nxt = total_r;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  assign held32_nxt = SEQ_W'(held_nxt);
  assign rd_en      = adv && rd_nxt;

  // Entry storage: value and byte width side by side.
  crh_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (adv && wr_en),
    .wr_addr (slot),
    .wr_data ({in_r.push_width, in_r.push_value}),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_entry)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Ring state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      held_r   <= '0;
      total_r  <= '0;
      cursor_r <= '0;
    end else if (adv) begin
      head_r   <= head_nxt;
      held_r   <= held_nxt;
      total_r  <= total_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r     <= ok_nxt;
      rd_r     <= rd_nxt;
      oldest_r <= total_nxt - held32_nxt;
      newest_r <= total_nxt - SEQ_W'(1);
      fill_r   <= held32_nxt[FILL_W-1:0];
    end
  end

  // Result payload: read data appears only for a successful get or pop.
  assign out_valid              = out_v_r;
  assign out_data.ok            = ok_r;
  assign out_data.code_value    = rd_r ? rd_entry[VALUE_W-1:0] : '0;
  assign out_data.code_width    = rd_r ? rd_entry[EW-1:VALUE_W] : '0;
  assign out_data.oldest_number = oldest_r;
  assign out_data.newest_number = newest_r;
  assign out_data.fill_count    = fill_r;

endmodule

// ----- hw/rtl/crh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ----------------------------------------------------------------------------
module crh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
